// ===== hdl/rrd_pkg.sv =====
// Shared types and constants for the respiration rate detector.
package rrd_pkg;

    // Configuration register widths
    localparam int CFG_W    = 13;
    localparam int FLOOR_W  = 13;
    localparam int TICK_W   = 8;
    localparam int SCALE_W  = 10;
    localparam int TALLY_W  = 8;
    localparam int RATE_W   = 8;
    localparam int ADDR_W   = 3;

    // Dividend width of the rate division: scale times breath count
    localparam int DIVD_W   = SCALE_W + TALLY_W;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_PEAK_FLOOR     = 3'd0;
    localparam logic [ADDR_W-1:0] REG_VALLEY_CEILING = 3'd1;
    localparam logic [ADDR_W-1:0] REG_REPORT_AFTER   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_GIVE_UP_AT     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_RATE_SCALE     = 3'd4;

    // Configuration reset values
    localparam logic [FLOOR_W-1:0] PEAK_FLOOR_RST     = 13'd3735;
    localparam logic [FLOOR_W-1:0] VALLEY_CEILING_RST = 13'd3624;
    localparam logic [TICK_W-1:0]  REPORT_AFTER_RST   = 8'd150;
    localparam logic [TICK_W-1:0]  GIVE_UP_AT_RST     = 8'd200;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST     = 10'd300;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_VLIM,
        ST_PLIM,
        ST_CMP,
        ST_DRAIN,
        ST_DECIDE,
        ST_DIV_START,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/rrd_front.sv =====
// Sample window, running sum, extremum detection and the extremum lists.
module rrd_front #(
    parameter int TAPS        = 7,
    parameter int BATCH       = 6,
    parameter int SAMPLE_BITS = 10,
    localparam int SUM_W      = SAMPLE_BITS + $clog2(TAPS),
    localparam int CNT_W      = $clog2(BATCH + 1),
    localparam int IDX_W      = $clog2(BATCH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [SAMPLE_BITS-1:0]       sample,
    input  logic [rrd_pkg::FLOOR_W-1:0]  peak_floor,
    input  logic [rrd_pkg::FLOOR_W-1:0]  valley_ceiling,
    input  logic                         clear_lists,
    input  logic                         rd_peak,
    input  logic [IDX_W-1:0]             rd_idx,
    output logic                         tick,
    output logic [CNT_W-1:0]             peak_cnt,
    output logic [CNT_W-1:0]             valley_cnt,
    output logic [SUM_W-1:0]             rd_data
);
    import rrd_pkg::*;

    localparam int SEEN_W = $clog2(TAPS + 1);
    localparam int CMP_W  = (SUM_W > FLOOR_W) ? SUM_W : FLOOR_W;

    logic [SAMPLE_BITS-1:0] window_reg [TAPS];
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SEEN_W-1:0]      seen_reg, seen_next;
    logic [1:0]             sums_seen_reg;
    logic [SUM_W-1:0]       recent_reg [2];
    logic [SUM_W-1:0]       peak_list [BATCH];
    logic [SUM_W-1:0]       valley_list [BATCH];
    logic [CNT_W-1:0]       peak_cnt_reg, valley_cnt_reg;
    logic                   full;
    logic                   is_peak, is_valley;
    logic [SUM_W-1:0]       mid, older;

    // Running window sum: add the newest sample, drop the oldest one
    assign sum_next  = sum_reg + SUM_W'(sample) - SUM_W'(window_reg[TAPS-1]);
    assign seen_next = (seen_reg == SEEN_W'(TAPS)) ? seen_reg : seen_reg + 1'b1;
    assign full      = (seen_next == SEEN_W'(TAPS));
    assign tick      = accept && full && (sums_seen_reg >= 2'd2);

    // Middle sum of the history is tested against its neighbors
    assign mid       = recent_reg[0];
    assign older     = recent_reg[1];
    assign is_peak   = (mid > older) && (mid >= sum_next)
                       && (CMP_W'(mid) >= CMP_W'(peak_floor));
    assign is_valley = !is_peak && (mid < older) && (mid <= sum_next)
                       && (CMP_W'(mid) <= CMP_W'(valley_ceiling));

    // Window, sum history and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg       <= '0;
            seen_reg      <= '0;
            sums_seen_reg <= '0;
            recent_reg[0] <= '0;
            recent_reg[1] <= '0;
        end
        else if (accept)
        begin
            for (int i = TAPS - 1; i > 0; i--)
            begin
                window_reg[i] <= window_reg[i-1];
            end
            window_reg[0] <= sample;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            if (full)
            begin
                recent_reg[1] <= recent_reg[0];
                recent_reg[0] <= sum_next;
                if (sums_seen_reg != 2'd3)
                begin
                    sums_seen_reg <= sums_seen_reg + 2'd1;
                end
            end
        end
    end

    // Extremum counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_cnt_reg   <= '0;
            valley_cnt_reg <= '0;
        end
        else if (clear_lists)
        begin
            peak_cnt_reg   <= '0;
            valley_cnt_reg <= '0;
        end
        else if (tick)
        begin
            if (is_peak && (peak_cnt_reg < CNT_W'(BATCH)))
            begin
                peak_cnt_reg <= peak_cnt_reg + 1'b1;
            end
            else if (is_valley && (valley_cnt_reg < CNT_W'(BATCH)))
            begin
                valley_cnt_reg <= valley_cnt_reg + 1'b1;
            end
        end
    end

    // Extremum lists, written at the current count
    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            if (is_peak && (peak_cnt_reg < CNT_W'(BATCH)))
            begin
                peak_list[peak_cnt_reg[IDX_W-1:0]] <= mid;
            end
            else if (is_valley && (valley_cnt_reg < CNT_W'(BATCH)))
            begin
                valley_list[valley_cnt_reg[IDX_W-1:0]] <= mid;
            end
        end
    end

    assign peak_cnt   = peak_cnt_reg;
    assign valley_cnt = valley_cnt_reg;
    assign rd_data    = rd_peak ? peak_list[rd_idx] : valley_list[rd_idx];

endmodule

// ===== hdl/rrd_mac.sv =====
// Shared multiply-accumulate unit used for batch limits, compares and the rate product.
module rrd_mac #(
    parameter int A_W   = 13,
    parameter int B_W   = 10,
    parameter int ACC_W = 27
) (
    input  logic             clk,
    input  logic             en,
    input  logic             clr,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic [ACC_W-1:0] acc
);
    logic [A_W+B_W-1:0] product;
    logic [ACC_W-1:0]   acc_reg;

    assign product = a * b;

    // Accumulate, or start over from the product alone
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= (clr ? '0 : acc_reg) + ACC_W'(product);
        end
    end

    assign acc = acc_reg;

endmodule

// ===== hdl/rrd_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module rrd_div #(
    parameter int DIVD_W = 18,
    parameter int DIVS_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVS_W-1:0] divs_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W:0]   shifted;
    logic              fits;

    // Bring down the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits    = (shifted >= {1'b0, divs_reg});

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            divs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIVS_W'(shifted - {1'b0, divs_reg}) : shifted[DIVS_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/respiration_rate_detector.sv =====
// Throughput: one sample at a time; in_ready is low while a tick is processed. A sample with no
// tick leaves in_ready high; a tick that scores no batch passes accept, check and decide. Scoring
// a batch walks the lists for the valley limit, peak limit and compares, then drains; a report
// adds the rate product and an 18-step divide, and every result then loads the output register,
// waiting while it is held. A waiting result also blocks the next sample. Reset (async, active low)
// clears window, sums, counts, tallies, ticks and loads the default configuration; lists hold none.
module respiration_rate_detector #(
    parameter int TAPS        = 7,
    parameter int BATCH       = 6,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_BITS-1:0]      sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rrd_pkg::RATE_W-1:0]  rate,
    output logic                        timed_out,
    input  logic                        cfg_wr_en,
    input  logic [rrd_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [rrd_pkg::CFG_W-1:0]   cfg_wdata
);
    import rrd_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + $clog2(TAPS);
    localparam int CNT_W   = $clog2(BATCH + 1);
    localparam int IDX_W   = $clog2(BATCH);
    localparam int KMAX    = 10 * (BATCH / 2) * (BATCH - BATCH / 2);
    localparam int LMAX    = 7 * BATCH;
    localparam int COEF_W  = $clog2(((KMAX > LMAX) ? KMAX : LMAX) + 1);
    localparam int OPB_W   = (COEF_W > SCALE_W) ? COEF_W : SCALE_W;
    localparam int ACC_W   = SUM_W + OPB_W + $clog2(BATCH) + 1;

    // Configuration registers
    logic [FLOOR_W-1:0] peak_floor_reg, valley_ceiling_reg;
    logic [TICK_W-1:0]  report_after_reg, give_up_at_reg;
    logic [SCALE_W-1:0] rate_scale_reg;

    // Sequencer and result state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic               pend_reg, pend_next;
    logic               pend_peak_reg, pend_peak_next;
    logic               batch_reg, batch_next;
    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic [TALLY_W-1:0] peak_tally_reg, peak_tally_next;
    logic [TALLY_W-1:0] valley_tally_reg, valley_tally_next;
    logic [RATE_W-1:0]  res_rate_reg, res_rate_next;
    logic               res_to_reg, res_to_next;
    logic               out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic               timed_out_reg, timed_out_next;
    logic [ACC_W-1:0]   vlim_reg, vlim_next;
    logic [ACC_W-1:0]   plim_reg, plim_next;

    // Datapath connections
    logic               accept;
    logic               tick;
    logic               clear_lists;
    logic               rd_peak;
    logic [IDX_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   np, nv;
    logic [SUM_W-1:0]   rd_data;
    logic               mac_en, mac_clr;
    logic [SUM_W-1:0]   mac_a;
    logic [OPB_W-1:0]   mac_b;
    logic [ACC_W-1:0]   acc;
    logic               div_start, div_done;
    logic [DIVD_W-1:0]  quotient;
    logic [OPB_W-1:0]   np_b, nv_b;
    logic [OPB_W-1:0]   c3_nv, c7_nv, c3_np, c7_np, k_coef;
    logic [2*CNT_W-1:0] np_nv;
    logic [TALLY_W:0]   tally_sum;
    logic [TALLY_W-1:0] breaths;
    logic               last_j;
    logic               batch_full;
    logic               report_ok;

    assign accept = in_valid && in_ready;

    // Front end: window, sums and extremum lists
    rrd_front #(
        .TAPS        (TAPS),
        .BATCH       (BATCH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .sample         (sample),
        .peak_floor     (peak_floor_reg),
        .valley_ceiling (valley_ceiling_reg),
        .clear_lists    (clear_lists),
        .rd_peak        (rd_peak),
        .rd_idx         (rd_idx),
        .tick           (tick),
        .peak_cnt       (np),
        .valley_cnt     (nv),
        .rd_data        (rd_data)
    );

    // Shared multiply-accumulate unit
    rrd_mac #(
        .A_W   (SUM_W),
        .B_W   (OPB_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .clk (clk),
        .en  (mac_en),
        .clr (mac_clr),
        .a   (mac_a),
        .b   (mac_b),
        .acc (acc)
    );

    // Serial divider for the rate
    rrd_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (TICK_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc[DIVD_W-1:0]),
        .divisor  (tick_count_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Walk over peaks first, then valleys
    assign rd_peak = (CNT_W'(j_reg) < np);
    assign rd_idx  = rd_peak ? j_reg : IDX_W'(CNT_W'(j_reg) - np);
    assign last_j  = (j_reg == IDX_W'(BATCH - 1));

    // Small coefficients of the cross-multiplied compares
    assign np_b   = OPB_W'(np);
    assign nv_b   = OPB_W'(nv);
    assign c3_nv  = (nv_b << 1) + nv_b;
    assign c7_nv  = (nv_b << 3) - nv_b;
    assign c3_np  = (np_b << 1) + np_b;
    assign c7_np  = (np_b << 3) - np_b;
    assign np_nv  = np * nv;
    assign k_coef = OPB_W'({np_nv, 3'b000}) + OPB_W'({np_nv, 1'b0});

    assign tally_sum  = {1'b0, peak_tally_reg} + {1'b0, valley_tally_reg};
    assign breaths    = tally_sum[TALLY_W:1];
    assign batch_full = ({1'b0, np} + {1'b0, nv}) >= (CNT_W + 1)'(BATCH);
    assign report_ok  = batch_reg && (tick_count_reg > report_after_reg)
                        && (tick_count_reg < give_up_at_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_floor_reg     <= PEAK_FLOOR_RST;
            valley_ceiling_reg <= VALLEY_CEILING_RST;
            report_after_reg   <= REPORT_AFTER_RST;
            give_up_at_reg     <= GIVE_UP_AT_RST;
            rate_scale_reg     <= RATE_SCALE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_PEAK_FLOOR:     peak_floor_reg     <= cfg_wdata[FLOOR_W-1:0];
                REG_VALLEY_CEILING: valley_ceiling_reg <= cfg_wdata[FLOOR_W-1:0];
                REG_REPORT_AFTER:   report_after_reg   <= cfg_wdata[TICK_W-1:0];
                REG_GIVE_UP_AT:     give_up_at_reg     <= cfg_wdata[TICK_W-1:0];
                REG_RATE_SCALE:     rate_scale_reg     <= cfg_wdata[SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            j_reg            <= '0;
            pend_reg         <= 1'b0;
            pend_peak_reg    <= 1'b0;
            batch_reg        <= 1'b0;
            tick_count_reg   <= '0;
            peak_tally_reg   <= '0;
            valley_tally_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            j_reg            <= j_next;
            pend_reg         <= pend_next;
            pend_peak_reg    <= pend_peak_next;
            batch_reg        <= batch_next;
            tick_count_reg   <= tick_count_next;
            peak_tally_reg   <= peak_tally_next;
            valley_tally_reg <= valley_tally_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vlim_reg      <= vlim_next;
        plim_reg      <= plim_next;
        res_rate_reg  <= res_rate_next;
        res_to_reg    <= res_to_next;
        rate_reg      <= rate_next;
        timed_out_reg <= timed_out_next;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next        = state_reg;
        j_next            = j_reg;
        pend_next         = 1'b0;
        pend_peak_next    = pend_peak_reg;
        batch_next        = batch_reg;
        tick_count_next   = tick_count_reg;
        peak_tally_next   = peak_tally_reg;
        valley_tally_next = valley_tally_reg;
        res_rate_next     = res_rate_reg;
        res_to_next       = res_to_reg;
        out_valid_next    = out_valid_reg;
        rate_next         = rate_reg;
        timed_out_next    = timed_out_reg;
        vlim_next         = vlim_reg;
        plim_next         = plim_reg;
        clear_lists       = 1'b0;
        mac_en            = 1'b0;
        mac_clr           = 1'b0;
        mac_a             = rd_data;
        mac_b             = k_coef;
        div_start         = 1'b0;

        // Output beat leaves when taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Compare result of the previous cycle feeds the tallies
        if (pend_reg)
        begin
            if (pend_peak_reg)
            begin
                if ((acc >= plim_reg) && (peak_tally_reg != '1))
                begin
                    peak_tally_next = peak_tally_reg + 1'b1;
                end
            end
            else
            begin
                if ((acc <= vlim_reg) && (valley_tally_reg != '1))
                begin
                    valley_tally_next = valley_tally_reg + 1'b1;
                end
            end
        end

        unique case (state_reg)
            // Samples that bring no tick only fill the window and the sum history
            ST_IDLE:
            begin
                if (accept && tick)
                begin
                    tick_count_next = tick_count_reg + 1'b1;
                    state_next      = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                j_next = '0;
                if (batch_full)
                begin
                    batch_next = 1'b1;
                    if ((np != '0) && (nv != '0))
                    begin
                        state_next = ST_VLIM;
                    end
                    else
                    begin
                        clear_lists = 1'b1;
                        state_next  = ST_DECIDE;
                    end
                end
                else
                begin
                    batch_next = 1'b0;
                    state_next = ST_DECIDE;
                end
            end

            // Valley limit: sum of peaks times 3nv plus valleys times 7np
            ST_VLIM:
            begin
                mac_en  = 1'b1;
                mac_clr = (j_reg == '0);
                mac_b   = rd_peak ? c3_nv : c7_np;
                j_next  = j_reg + 1'b1;
                if (last_j)
                begin
                    j_next     = '0;
                    state_next = ST_PLIM;
                end
            end

            // Peak limit: sum of peaks times 7nv plus valleys times 3np
            ST_PLIM:
            begin
                if (j_reg == '0)
                begin
                    vlim_next = acc;
                end
                mac_en  = 1'b1;
                mac_clr = (j_reg == '0);
                mac_b   = rd_peak ? c7_nv : c3_np;
                j_next  = j_reg + 1'b1;
                if (last_j)
                begin
                    j_next     = '0;
                    state_next = ST_CMP;
                end
            end

            // Each extremum times 10*np*nv, checked in the next cycle
            ST_CMP:
            begin
                if (j_reg == '0)
                begin
                    plim_next = acc;
                end
                mac_en         = 1'b1;
                mac_clr        = 1'b1;
                mac_b          = k_coef;
                pend_next      = 1'b1;
                pend_peak_next = rd_peak;
                j_next         = j_reg + 1'b1;
                if (last_j)
                begin
                    j_next     = '0;
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                clear_lists = 1'b1;
                state_next  = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (report_ok)
                begin
                    mac_en     = 1'b1;
                    mac_clr    = 1'b1;
                    mac_a      = SUM_W'(breaths);
                    mac_b      = OPB_W'(rate_scale_reg);
                    state_next = ST_DIV_START;
                end
                else if (tick_count_reg >= give_up_at_reg)
                begin
                    res_rate_next   = '0;
                    res_to_next     = 1'b1;
                    tick_count_next = '0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    res_rate_next     = (quotient[DIVD_W-1:RATE_W] != '0) ? '1
                                        : quotient[RATE_W-1:0];
                    res_to_next       = 1'b0;
                    tick_count_next   = '0;
                    peak_tally_next   = '0;
                    valley_tally_next = '0;
                    state_next        = ST_EMIT;
                end
            end

            // Load the output register once it is free
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    rate_next      = res_rate_reg;
                    timed_out_next = res_to_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign rate      = rate_reg;
    assign timed_out = timed_out_reg;

endmodule

// ===== dv/respiration_rate_detector_tb.sv =====
// Self-checking testbench for the respiration rate detector: breath-shaped stimulus, scoreboard.
module respiration_rate_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrd_pkg::*;

    localparam int TAPS          = 7;
    localparam int BATCH         = 6;
    localparam int SAMPLE_BITS   = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int MAX_REPORTS   = 10;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [RATE_W-1:0] rate;
        logic              timed_out;
    } rate_beat_t;

    // Tracks the detector state and holds the rate beats still owed by the block.
    class rate_scoreboard;
        logic [FLOOR_W-1:0]     peak_floor, valley_ceiling;
        logic [TICK_W-1:0]      report_after, give_up_at;
        logic [SCALE_W-1:0]     rate_scale;

        logic [SAMPLE_BITS-1:0] window [TAPS];
        logic [FLOOR_W-1:0]     sum_mid, sum_old;
        logic [FLOOR_W-1:0]     peaks [BATCH];
        logic [FLOOR_W-1:0]     valleys [BATCH];
        int unsigned            n_samples, n_sums, n_peaks, n_valleys;
        int unsigned            ticks, peak_tally, valley_tally;

        rate_beat_t             expected_q [$];
        int unsigned            mismatches, checked, reports, timeouts;
        bit                     tally_saturated;

        function new();
            peak_floor      = PEAK_FLOOR_RST;
            valley_ceiling  = VALLEY_CEILING_RST;
            report_after    = REPORT_AFTER_RST;
            give_up_at      = GIVE_UP_AT_RST;
            rate_scale      = RATE_SCALE_RST;
            foreach (window[i]) window[i] = '0;
            sum_mid         = '0;
            sum_old         = '0;
            n_samples       = 0;
            n_sums          = 0;
            n_peaks         = 0;
            n_valleys       = 0;
            ticks           = 0;
            peak_tally      = 0;
            valley_tally    = 0;
            mismatches      = 0;
            checked         = 0;
            reports         = 0;
            timeouts        = 0;
            tally_saturated = 1'b0;
        endfunction

        function void set_register(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
            case (addr)
                REG_PEAK_FLOOR:     peak_floor     = data[FLOOR_W-1:0];
                REG_VALLEY_CEILING: valley_ceiling = data[FLOOR_W-1:0];
                REG_REPORT_AFTER:   report_after   = data[TICK_W-1:0];
                REG_GIVE_UP_AT:     give_up_at     = data[TICK_W-1:0];
                REG_RATE_SCALE:     rate_scale     = data[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned bump(int unsigned tally);
            if (tally >= 255) tally_saturated = 1'b1;
            return (tally < 255) ? tally + 1 : 255;
        endfunction

        // Score a full batch of extrema against the cross-multiplied thresholds.
        function void score_batch();
            int unsigned sp, sv, vlim, plim, i;
            sp = 0;
            sv = 0;
            for (i = 0; i < n_peaks; i++) sp += peaks[i];
            for (i = 0; i < n_valleys; i++) sv += valleys[i];
            if (n_peaks != 0 && n_valleys != 0)
            begin
                vlim = 3 * sp * n_valleys + 7 * sv * n_peaks;
                plim = 7 * sp * n_valleys + 3 * sv * n_peaks;
                for (i = 0; i < n_valleys; i++)
                    if (10 * valleys[i] * n_peaks * n_valleys <= vlim)
                        valley_tally = bump(valley_tally);
                for (i = 0; i < n_peaks; i++)
                    if (10 * peaks[i] * n_peaks * n_valleys >= plim)
                        peak_tally = bump(peak_tally);
            end
            n_peaks   = 0;
            n_valleys = 0;
        endfunction

        // Advance the detector by one accepted sample and queue any rate beat it owes.
        function void note_sample(logic [SAMPLE_BITS-1:0] s);
            int unsigned total, breaths, quotient, i;
            logic [FLOOR_W-1:0] older, mid;
            rate_beat_t res;
            bit emit;
            emit = 1'b0;
            res  = '0;
            for (i = TAPS - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = s;
            if (n_samples < TAPS) n_samples++;
            if (n_samples < TAPS) return;

            total = 0;
            for (i = 0; i < TAPS; i++) total += window[i];
            older   = sum_old;
            mid     = sum_mid;
            sum_old = mid;
            sum_mid = FLOOR_W'(total);
            if (n_sums < 3) n_sums++;
            if (n_sums < 3) return;

            // Middle sum of the history is the extremum candidate.
            ticks++;
            if (mid > older && mid >= total && mid >= peak_floor)
            begin
                if (n_peaks < BATCH)
                begin
                    peaks[n_peaks] = mid;
                    n_peaks++;
                end
            end
            else if (mid < older && mid <= total && mid <= valley_ceiling)
            begin
                if (n_valleys < BATCH)
                begin
                    valleys[n_valleys] = mid;
                    n_valleys++;
                end
            end

            if (n_peaks + n_valleys >= BATCH)
            begin
                score_batch();
                if (ticks > report_after && ticks < give_up_at)
                begin
                    breaths       = (peak_tally + valley_tally) / 2;
                    quotient      = rate_scale * breaths / ticks;
                    res.rate      = (quotient > 255) ? RATE_W'(255) : RATE_W'(quotient);
                    res.timed_out = 1'b0;
                    emit          = 1'b1;
                    peak_tally    = 0;
                    valley_tally  = 0;
                    ticks         = 0;
                    reports++;
                end
            end

            // Give up once the tick count reaches the limit; tallies survive.
            if (ticks >= give_up_at)
            begin
                res.rate      = '0;
                res.timed_out = 1'b1;
                emit          = 1'b1;
                ticks         = 0;
                timeouts++;
            end
            if (emit) expected_q.insert(expected_q.size(), res);
        endfunction

        function void log_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
        endfunction

        // Compare one result beat with the oldest owed beat.
        function void check_result(logic [RATE_W-1:0] got_rate, logic got_tout);
            rate_beat_t want;
            if (expected_q.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result beat: rate %0d timed_out %0b",
                                       got_rate, got_tout));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got_rate !== want.rate || got_tout !== want.timed_out)
                log_mismatch($sformatf({"result beat %0d: expected rate %0d timed_out %0b, ",
                                        "got rate %0d timed_out %0b"}, checked, want.rate,
                                       want.timed_out, got_rate, got_tout));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [RATE_W-1:0]      rate;
    logic                   timed_out;
    logic                   cfg_wr_en;
    logic [ADDR_W-1:0]      cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;

    rate_scoreboard sb = new();
    int  samples_sent  = 0;
    int  settings_seen = 0;
    int  in_gap_pct    = 0;
    int  out_stall_pct = 0;
    bit  calm          = 1'b0;

    respiration_rate_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rate      (rate),
        .timed_out (timed_out),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Result side: random stall bursts, none once the run turns calm.
    always
    begin
        @(posedge clk);
        if (!calm && $urandom_range(0, 99) < out_stall_pct)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        out_ready <= 1'b1;
    end

    // Every accepted result beat goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid && out_ready)
            sb.check_result(rate, timed_out);
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #15ms;
        $display("respiration_rate_detector_tb: FAIL");
        $finish;
    end

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_register(addr, data);
    endtask

    task automatic program_regs(input logic [FLOOR_W-1:0] floor_v, input logic [FLOOR_W-1:0] ceil_v,
                                input logic [TICK_W-1:0] report_v, input logic [TICK_W-1:0] give_v,
                                input logic [SCALE_W-1:0] scale_v);
        write_reg(REG_PEAK_FLOOR, CFG_W'(floor_v));
        write_reg(REG_VALLEY_CEILING, CFG_W'(ceil_v));
        write_reg(REG_REPORT_AFTER, CFG_W'(report_v));
        write_reg(REG_GIVE_UP_AT, CFG_W'(give_v));
        write_reg(REG_RATE_SCALE, CFG_W'(scale_v));
        cfg_wr_en <= 1'b0;
        settings_seen++;
    endtask

    task automatic random_regs();
        program_regs(FLOOR_W'($urandom_range(2800, 4600)), FLOOR_W'($urandom_range(2700, 4300)),
                     TICK_W'($urandom_range(0, 160)), TICK_W'($urandom_range(1, 255)),
                     SCALE_W'($urandom_range(1, 1023)));
    endtask

    // Present one sample beat, optionally after an idle burst, and wait for acceptance.
    task automatic send_sample(input int value);
        if (!calm && $urandom_range(0, 99) < in_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= SAMPLE_BITS'(value);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_sample(SAMPLE_BITS'(value));
        samples_sent++;
    endtask

    // Lower valid and let every owed beat arrive.
    task automatic wait_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Idle point for a register write: all beats in, then the batch/divide latency.
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One waveform segment: triangle breathing, flat line, noise, square or alternation.
    task automatic play_segment(input int max_period, input int force_kind, input int left);
        int kind, n, period, half, base, amp, noise, hold, i, phase, v;
        kind          = (force_kind >= 0) ? force_kind : $urandom_range(0, 9);
        n             = $urandom_range(20, 120);
        if (n > left) n = left;
        period        = $urandom_range(4, max_period);
        half          = period / 2;
        base          = $urandom_range(380, 660);
        amp           = $urandom_range(20, 480);
        noise         = $urandom_range(0, 30);
        hold          = $urandom_range(1, 12);
        in_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 60);
        for (i = 0; i < n; i++)
        begin
            case (kind)
                0: v = base + int'($urandom_range(0, 2 * noise)) - noise;
                1: v = $urandom_range(0, 1023);
                2: v = ((i / hold) % 2 == 0) ? 1023 : 0;
                3: v = (i % 2 == 0) ? $urandom_range(880, 1023) : $urandom_range(0, 140);
                default:
                begin
                    phase = i % period;
                    if (phase < half) v = base - amp + (2 * amp * phase) / half;
                    else v = base + amp - (2 * amp * (phase - half)) / (period - half);
                    v = v + int'($urandom_range(0, 2 * noise)) - noise;
                end
            endcase
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            send_sample(v);
        end
    endtask

    task automatic run_phase(input int quota, input int max_period, input int kind);
        int start;
        start = samples_sent;
        while (samples_sent - start < quota)
            play_segment(max_period, kind, quota - (samples_sent - start));
    endtask

    initial
    begin
        int i;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        sample    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default thresholds, written explicitly.
        program_regs(PEAK_FLOOR_RST, VALLEY_CEILING_RST, REPORT_AFTER_RST,
                     GIVE_UP_AT_RST, RATE_SCALE_RST);

        // Directed: full-scale plateaus, zero plateaus, bit-toggling alternation, walking bits.
        for (i = 0; i < 7; i++) send_sample(1023);
        for (i = 0; i < 7; i++) send_sample(0);
        for (i = 0; i < 6; i++) send_sample((i % 2 == 0) ? 'h2AA : 'h155);
        for (i = 0; i < 5; i++) send_sample(1 << (2 * i));
        run_phase(200, 40, -1);
        wait_idle();

        // Frequent reports, rates pushed into saturation; hold the sender mid-phase.
        program_regs(PEAK_FLOOR_RST, VALLEY_CEILING_RST, 8'd0, 8'd40, 10'd1023);
        run_phase(100, 24, -1);
        wait_results();
        run_phase(100, 24, -1);
        wait_idle();

        // Never report: tallies climb to saturation across give-ups.
        program_regs(PEAK_FLOOR_RST, VALLEY_CEILING_RST, 8'd255, 8'd255, RATE_SCALE_RST);
        run_phase(560, 8, 3);
        wait_idle();

        // Report with the saturated tallies at the smallest scale.
        program_regs(PEAK_FLOOR_RST, VALLEY_CEILING_RST, 8'd0, 8'd255, 10'd1);
        run_phase(120, 30, -1);
        wait_idle();

        // Widest thresholds: every local extremum qualifies.
        program_regs(13'd0, 13'd7161, 8'd20, 8'd120, 10'd600);
        run_phase(150, 30, -1);
        wait_idle();

        // Tightest thresholds and give-up on every tick.
        program_regs(13'd7161, 13'd0, 8'd0, 8'd1, 10'd1023);
        run_phase(100, 8, 2);
        wait_idle();

        // Random settings.
        for (i = 0; i < 3; i++)
        begin
            random_regs();
            run_phase(150, 48, -1);
            wait_idle();
        end

        // Last stretch without idling on either side.
        random_regs();
        calm = 1'b1;
        run_phase(150, 48, -1);
        wait_idle();

        $display("Covered %0d samples over %0d register settings: %0d rate reports, %0d give-ups.",
                 samples_sent, settings_seen, sb.reports, sb.timeouts);
        $display("Result beats checked: %0d, mismatches: %0d, tally saturation reached: %0b.",
                 sb.checked, sb.mismatches, sb.tally_saturated);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("respiration_rate_detector_tb: PASS");
        else
            $display("respiration_rate_detector_tb: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rrd_pkg.sv
hdl/rrd_front.sv
hdl/rrd_mac.sv
hdl/rrd_div.sv
hdl/respiration_rate_detector.sv
dv/respiration_rate_detector_tb.sv
